// ----- rtl/core/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types, constants and codes of the pattern step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

    // Store geometry
    localparam int PATTERN_COUNT     = 10;
    localparam int STEPS_PER_PATTERN = 8;
    localparam int CELL_COUNT        = PATTERN_COUNT * STEPS_PER_PATTERN;
    localparam int CELL_AW           = $clog2(CELL_COUNT);
    localparam int STEP_W            = $clog2(STEPS_PER_PATTERN);

    // Field widths
    localparam int ACT_W    = 3;
    localparam int PIDX_W   = 4;
    localparam int SLOT_W   = 3;
    localparam int CODE_W   = 9;
    localparam int KIND_W   = 2;
    localparam int SLICE_W  = 7;
    localparam int GEN_W    = 32;
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 48;
    localparam int M_USER_W = 3;

    // Timing widths (Q16 fixed point)
    localparam int FRAC_W     = 16;
    localparam int SAMPLE_W   = 40;
    localparam int TIME_W     = 56;
    localparam int STEP_IV_W  = 36;
    localparam int MIN_IV_W   = 28;
    localparam int MODE_W     = 2;
    localparam int SPREAD_W   = 15;
    localparam int SEED_W     = 32;
    localparam int SEL_W      = 4;
    localparam int FACTOR_W   = 17;
    localparam int MAG_W      = 33;
    localparam int PROD_W     = 49;
    localparam int PROD_SHIFT = 32;
    localparam int SCALED_W   = STEP_IV_W + FACTOR_W;
    localparam int ADV_W      = SCALED_W - FRAC_W;

    // Configuration port
    localparam int CFG_AW = 6;
    localparam int CFG_DW = 64;

    localparam logic [CODE_W-1:0]   GAP_CODE     = 9'd256;
    localparam logic [CODE_W-1:0]   SLICE_A_MAX  = 9'd127;
    localparam logic [CODE_W-1:0]   SLICE_B_MAX  = 9'd255;
    localparam logic [SEED_W-1:0]   DEFAULT_SEED = 32'h4e41_5632;
    localparam logic [FACTOR_W-1:0] UNITY_Q16    = 17'd65536;
    localparam logic [FACTOR_W-1:0] FREE_BASE    = 17'd31457;  // 0.48
    localparam logic [FACTOR_W-1:0] FREE_SPAN    = 17'd70779;  // 1.08
    localparam logic [MAG_W-1:0]    HALF_RANGE   = 33'h1_0000_0000;

    // Register reset values
    localparam logic [STEP_IV_W-1:0] STEP_IV_RST = 36'd1572864000;
    localparam logic [MIN_IV_W-1:0]  MIN_IV_RST  = 28'd56623104;
    localparam logic [SEED_W-1:0]    SEED_RST    = 32'd1312904754;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 3'd0,
        ACT_START = 3'd1,
        ACT_STOP  = 3'd2,
        ACT_RESET = 3'd3,
        ACT_WRITE = 3'd4
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        TM_STRAIGHT = 2'd0,
        TM_JITTER   = 2'd1,
        TM_FREE     = 2'd2
    } timing_mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_A   = 2'd0,
        KIND_B   = 2'd1,
        KIND_GAP = 2'd2
    } cell_kind_t;

    typedef enum logic [2:0] {
        REG_STEP_INTERVAL    = 3'd0,
        REG_MIN_INTERVAL     = 3'd1,
        REG_TIMING_MODE      = 3'd2,
        REG_JITTER_SPREAD    = 3'd3,
        REG_SEED             = 3'd4,
        REG_SELECTED_PATTERN = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FACTOR,
        ST_SCALE,
        ST_ADVANCE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic [STEP_IV_W-1:0] step_interval;
        logic [MIN_IV_W-1:0]  min_interval;
        logic [MODE_W-1:0]    timing_mode;
        logic [SPREAD_W-1:0]  jitter_spread;
        logic [SEED_W-1:0]    seed;
        logic [SEL_W-1:0]     selected_pattern;
    } cfg_t;

    typedef struct packed {
        logic load;     // capture the accepted request
        logic exec;     // carry out the action, read the step's cell
        logic factor;   // first product of the random factor
        logic scale;    // step interval times factor
        logic advance;  // move the next event time
        logic emit;     // load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic fire;      // tick is due and the transport runs
        logic out_free;  // result register can take a new result
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/pss_regs.sv -----
// ----------------------------------------------------------------------------
// pss_regs
// APB-style configuration register file of the pattern step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_regs
    import pss_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[CFG_AW-1:3];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_interval    <= STEP_IV_RST;
            cfg_reg.min_interval     <= MIN_IV_RST;
            cfg_reg.timing_mode      <= TM_STRAIGHT;
            cfg_reg.jitter_spread    <= '0;
            cfg_reg.seed             <= SEED_RST;
            cfg_reg.selected_pattern <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_STEP_INTERVAL:    cfg_reg.step_interval    <= pwdata[STEP_IV_W-1:0];
                REG_MIN_INTERVAL:     cfg_reg.min_interval     <= pwdata[MIN_IV_W-1:0];
                REG_TIMING_MODE:      cfg_reg.timing_mode      <= pwdata[MODE_W-1:0];
                REG_JITTER_SPREAD:    cfg_reg.jitter_spread    <= pwdata[SPREAD_W-1:0];
                REG_SEED:             cfg_reg.seed             <= pwdata[SEED_W-1:0];
                REG_SELECTED_PATTERN: cfg_reg.selected_pattern <= pwdata[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STEP_INTERVAL:    prdata = CFG_DW'(cfg_reg.step_interval);
            REG_MIN_INTERVAL:     prdata = CFG_DW'(cfg_reg.min_interval);
            REG_TIMING_MODE:      prdata = CFG_DW'(cfg_reg.timing_mode);
            REG_JITTER_SPREAD:    prdata = CFG_DW'(cfg_reg.jitter_spread);
            REG_SEED:             prdata = CFG_DW'(cfg_reg.seed);
            REG_SELECTED_PATTERN: prdata = CFG_DW'(cfg_reg.selected_pattern);
            default:              prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/pss_ctrl.sv -----
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencing state machine: walks each request through execute and the
// result register, and a firing tick also through the timing multiplies.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_ctrl
    import pss_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  dp_status_t      status,
    output ctrl_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.fire ? ST_FACTOR : ST_EMIT;
            end
            ST_FACTOR: begin
                cmd.factor = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_ADVANCE;
            end
            ST_ADVANCE: begin
                cmd.advance = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                // hold until the previous result has been taken
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.exec, cmd.factor, cmd.scale, cmd.advance, cmd.emit}))
        else $error("more than one datapath command at once");

    a_no_fire_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && !status.fire) |=> state_reg == ST_EMIT)
        else $error("request without event did not go straight to emit");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && !status.out_free) |=> state_reg == ST_EMIT)
        else $error("result emitted over a pending result");

    a_fire_path: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.advance |-> $past(cmd.scale) && $past(cmd.factor, 2))
        else $error("event time advanced without both multiplies");

endmodule

`default_nettype wire

// ----- rtl/core/pss_dp.sv -----
// ----------------------------------------------------------------------------
// pss_dp
// Datapath: pattern store, transport state, xorshift32 generator, Q16
// scheduling arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_dp
    import pss_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [S_USER_W-1:0] s_tuser,
    input  cfg_t                     cfg,
    input  ctrl_cmd_t                cmd,
    output dp_status_t               status,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,
    output logic      [M_USER_W-1:0] m_tuser
);

    // captured request
    logic [ACT_W-1:0]  act_reg;
    logic [PIDX_W-1:0] pidx_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CODE_W-1:0] code_reg;

    // transport state
    logic [STEP_W-1:0]   step_ptr_reg;
    logic                running_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]   next_time_reg;
    logic [SEED_W-1:0]   rng_reg;
    logic [GEN_W-1:0]    gen_reg;

    // pattern store
    logic [CODE_W-1:0] cell_mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] cell_valid_reg;
    logic [CODE_W-1:0] rd_code_reg;
    logic              rd_valid_reg;
    logic [STEP_W-1:0] fired_step_reg;

    // per-request results and arithmetic
    logic                ev_valid_reg;
    logic                rejected_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SCALED_W-1:0] scaled_reg;

    // result register
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_USER_W-1:0] m_tuser_reg;

    logic                due;
    logic                fire;
    logic                random_mode;
    logic                write_ok;
    logic [SEL_W-1:0]    pat_sel;
    logic [CELL_AW-1:0]  rd_addr;
    logic [CELL_AW-1:0]  wr_addr;
    logic [SEED_W-1:0]   rng_step;
    logic [MAG_W-1:0]    twice;
    logic [MAG_W-1:0]    mag;
    logic [FACTOR_W-1:0] prod_hi;
    logic [FACTOR_W-1:0] factor;
    logic [ADV_W-1:0]    adv_raw;
    logic [ADV_W-1:0]    advance;
    logic [CODE_W-1:0]   cell_code;
    logic [KIND_W-1:0]   kind;
    logic [SLICE_W-1:0]  slice;
    logic [STEP_W-1:0]   ev_step;

    // ---- decisions ---------------------------------------------------------
    assign due  = {sample_reg, {FRAC_W{1'b0}}} >= next_time_reg;
    assign fire = (act_reg == ACT_TICK) && running_reg && due;

    assign random_mode = (cfg.timing_mode == TM_JITTER) || (cfg.timing_mode == TM_FREE);

    assign write_ok = (code_reg <= GAP_CODE)
                   && (32'(pidx_reg) < PATTERN_COUNT)
                   && (32'(slot_reg) < STEPS_PER_PATTERN);

    assign pat_sel = (32'(cfg.selected_pattern) >= PATTERN_COUNT)
                   ? SEL_W'(PATTERN_COUNT - 1) : cfg.selected_pattern;

    assign rd_addr = CELL_AW'(32'(pat_sel) * STEPS_PER_PATTERN + 32'(step_ptr_reg));
    assign wr_addr = CELL_AW'(32'(pidx_reg) * STEPS_PER_PATTERN + 32'(slot_reg));

    always_comb begin
        logic [SEED_W-1:0] x;
        x = rng_reg;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        rng_step = x;
    end

    assign status.fire     = fire;
    assign status.out_free = !m_tvalid_reg || m_tready;

    // ---- request capture ---------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_tuser[ACT_W-1:0];
            pidx_reg <= s_tdata[PIDX_W-1:0];
            slot_reg <= s_tdata[PIDX_W +: SLOT_W];
            code_reg <= s_tdata[PIDX_W+SLOT_W +: CODE_W];
        end
    end

    // ---- transport state ---------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_ptr_reg  <= '0;
            running_reg   <= 1'b0;
            sample_reg    <= '0;
            next_time_reg <= '0;
            rng_reg       <= DEFAULT_SEED;
            gen_reg       <= '0;
            ev_valid_reg  <= 1'b0;
            rejected_reg  <= 1'b0;
        end else if (cmd.exec) begin
            ev_valid_reg <= fire;
            rejected_reg <= (act_reg == ACT_WRITE) && !write_ok;
            case (act_reg)
                ACT_TICK: begin
                    if (fire) begin
                        step_ptr_reg <= (32'(step_ptr_reg) == STEPS_PER_PATTERN - 1)
                                      ? '0 : step_ptr_reg + 1'b1;
                        if (random_mode) begin
                            rng_reg <= rng_step;
                        end
                    end
                    sample_reg <= sample_reg + 1'b1;
                end
                ACT_START: begin
                    running_reg   <= 1'b1;
                    next_time_reg <= {sample_reg, {FRAC_W{1'b0}}};
                end
                ACT_STOP: begin
                    running_reg <= 1'b0;
                    gen_reg     <= gen_reg + 1'b1;
                end
                ACT_RESET: begin
                    step_ptr_reg  <= '0;
                    sample_reg    <= '0;
                    next_time_reg <= '0;
                    rng_reg       <= (cfg.seed == '0) ? DEFAULT_SEED : cfg.seed;
                    gen_reg       <= gen_reg + 1'b1;
                end
                default: ;
            endcase
        end else if (cmd.advance) begin
            next_time_reg <= next_time_reg + TIME_W'(advance);
        end
    end

    // ---- pattern store -----------------------------------------------------
    // An entry never written reads as its own step number.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_valid_reg <= '0;
        end else if (cmd.exec && act_reg == ACT_WRITE && write_ok) begin
            cell_valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && act_reg == ACT_WRITE && write_ok) begin
            cell_mem[wr_addr] <= code_reg;
        end
        if (cmd.exec) begin
            rd_code_reg    <= cell_mem[rd_addr];
            rd_valid_reg   <= cell_valid_reg[rd_addr];
            fired_step_reg <= step_ptr_reg;
        end
    end

    // ---- scheduling arithmetic ---------------------------------------------
    assign twice   = {rng_reg, 1'b0};
    assign mag     = rng_reg[SEED_W-1] ? (twice - HALF_RANGE) : (HALF_RANGE - twice);
    assign prod_hi = prod_reg[PROD_W-1:PROD_SHIFT];

    always_comb begin
        case (cfg.timing_mode)
            TM_JITTER: factor = rng_reg[SEED_W-1] ? (UNITY_Q16 + prod_hi)
                                                  : (UNITY_Q16 - prod_hi);
            TM_FREE:   factor = FREE_BASE + prod_hi;
            default:   factor = UNITY_Q16;
        endcase
    end

    assign adv_raw = scaled_reg[SCALED_W-1:FRAC_W];
    assign advance = (adv_raw < ADV_W'(cfg.min_interval)) ? ADV_W'(cfg.min_interval) : adv_raw;

    always_ff @(posedge aclk) begin
        if (cmd.factor) begin
            if (cfg.timing_mode == TM_JITTER) begin
                prod_reg <= PROD_W'(mag) * PROD_W'(cfg.jitter_spread);
            end else begin
                prod_reg <= PROD_W'(FREE_SPAN) * PROD_W'(rng_reg);
            end
        end
        if (cmd.scale) begin
            scaled_reg <= SCALED_W'(cfg.step_interval) * SCALED_W'(factor);
        end
    end

    // ---- cell decode and result register -----------------------------------
    assign cell_code = rd_valid_reg ? rd_code_reg : CODE_W'(fired_step_reg);

    always_comb begin
        kind    = KIND_A;
        slice   = '0;
        ev_step = '0;
        if (ev_valid_reg) begin
            ev_step = fired_step_reg;
            if (cell_code <= SLICE_A_MAX) begin
                kind  = KIND_A;
                slice = cell_code[SLICE_W-1:0];
            end else if (cell_code <= SLICE_B_MAX) begin
                kind  = KIND_B;
                slice = cell_code[SLICE_W-1:0];
            end else begin
                kind  = KIND_GAP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= M_DATA_W'({rejected_reg, gen_reg, running_reg, slice, ev_step});
            m_tuser_reg <= {kind, ev_valid_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pattern_step_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// pattern_step_sequencer_top
// Step sequencer with xorshift32 timing jitter, one result per request.
// ----------------------------------------------------------------------------
// Each request on the s_ channel is one action (sample tick, start, stop,
// reset, write of one pattern cell) and yields exactly one result on the m_
// channel. A request that fires no step goes from acceptance through execute
// to the result register; a firing tick also passes the factor, scale and
// advance states, as the next event time goes through the random-factor
// multiply, the step-interval multiply and the 56-bit advance add one after
// the other in the shared datapath. Requests are handled one at a time; the
// next one is accepted while the previous result still waits in the output
// register. The 10x8 pattern store has a valid bit per cell, so it reads as
// its reset contents right after reset with no clearing pass. Configuration
// registers sit at byte address 8*i on the APB-style port (64-bit data);
// the user must write them only while the block is idle; nothing enforces it.
// ----------------------------------------------------------------------------
`default_nettype none

module pattern_step_sequencer_top
    import pss_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    // requests
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // pattern_index[3:0], step_slot[6:4], cell_code[15:7]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // action[2:0]
    input  wire logic [S_USER_W-1:0] s_tuser,

    // results
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // event_step[2:0], slice_index[9:3], is_running[10],
    // transport_generation[42:11], write_rejected[43], zero[47:44]
    output logic      [M_DATA_W-1:0] m_tdata,
    // event_valid[0], cell_kind[2:1]
    output logic      [M_USER_W-1:0] m_tuser,

    // configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CFG_AW-1:0]   paddr,
    input  wire logic [CFG_DW-1:0]   pwdata,
    output logic      [CFG_DW-1:0]   prdata,
    output logic                     pready
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // register file: timing, seed and pattern selection
    pss_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller: sequence each request through the datapath
    pss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: store, transport state, scheduling and result register
    pss_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
